// File: design/sptpe_pkg.sv
// ----------------------------------------------------------------------------
// sptpe_pkg
// Shared types and constants of the splay-tree prefix encoder.
// ----------------------------------------------------------------------------
package sptpe_pkg;

  // Default number of plain symbols (bytes); the end symbol comes on top
  localparam int unsigned AlphabetDef = 256;

  localparam int unsigned ByteW = 8;

  // One input transaction
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             is_end;
  } in_item_t;

  // One output transaction
  typedef struct packed {
    logic [ByteW-1:0] code_byte;
    logic             last_of_run;
    logic             stream_done;
  } out_item_t;

endpackage

// File: design/sptpe_ram.sv
// ----------------------------------------------------------------------------
// sptpe_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is issued. Read returns old data.
// ----------------------------------------------------------------------------
module sptpe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: design/splay_tree_prefix_encoder.sv
// ----------------------------------------------------------------------------
// splay_tree_prefix_encoder
// Adaptive splay-tree prefix encoder with byte-packed output.
// ----------------------------------------------------------------------------
// One item is handled at a time. An item of code length L goes through the
// leaf-to-root walk (S_WALK_B/C per level), bit packing (S_EMIT_RD/BIT per
// bit), hand-over of the last byte, and the semi-splay (S_SPL_A to F per
// pairwise swap, about L/2 swaps); these steps read or write the tree
// memories, whose read data is registered. Output stalls can hold packing
// and hand-over. After reset and after every end item the tree memories are
// rebuilt by a pass over all 2*ALPHABET+1 nodes, during which no item is taken.
// ----------------------------------------------------------------------------
module splay_tree_prefix_encoder
  import sptpe_pkg::*;
#(
  parameter int unsigned ALPHABET = AlphabetDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned NumNodes = 2 * ALPHABET + 1;
  localparam int unsigned NodeW    = $clog2(NumNodes);
  localparam int unsigned InW      = $clog2(ALPHABET);

  // Sequencer states
  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_WALK_B   = 4'd2;
  localparam logic [3:0] S_WALK_C   = 4'd3;
  localparam logic [3:0] S_EMIT_RD  = 4'd4;
  localparam logic [3:0] S_EMIT_BIT = 4'd5;
  localparam logic [3:0] S_FLUSH    = 4'd6;
  localparam logic [3:0] S_FIN      = 4'd7;
  localparam logic [3:0] S_SPL_A    = 4'd8;
  localparam logic [3:0] S_SPL_B    = 4'd9;
  localparam logic [3:0] S_SPL_C    = 4'd10;
  localparam logic [3:0] S_SPL_D    = 4'd11;
  localparam logic [3:0] S_SPL_E    = 4'd12;
  localparam logic [3:0] S_SPL_F    = 4'd13;

  // Internal node guard: out-of-range index maps to the root
  function automatic logic [InW-1:0] inner(input logic [InW-1:0] c);
    inner = (int'(c) < int'(ALPHABET)) ? c : '0;
  endfunction

  // Byte reduction modulo ALPHABET, restoring subtract per bit
  function automatic logic [InW-1:0] sym_mod(input logic [ByteW-1:0] v);
    logic [ByteW+InW:0] r;
    logic [ByteW+InW:0] s;
    r = (ByteW+InW+1)'(v);
    for (int k = ByteW - 1; k >= 0; k--) begin
      s = (ByteW+InW+1)'(ALPHABET) << k;
      if (r >= s) begin
        r = r - s;
      end
    end
    sym_mod = r[InW-1:0];
  endfunction

  logic [3:0]       state_q, state_d;
  logic [NodeW-1:0] clr_q, clr_d;
  logic [NodeW-1:0] a_q, a_d;
  logic [NodeW-1:0] leaf_q, leaf_d;
  logic [InW-1:0]   c_q, c_d;
  logic [InW-1:0]   d_q, d_d;
  logic [NodeW-1:0] b_q, b_d;
  logic [NodeW-1:0] lc_q, lc_d;
  logic [InW:0]     depth_q, depth_d;
  logic             is_end_q, is_end_d;
  logic [2:0]       bp_q, bp_d;
  logic [ByteW-1:0] part_q, part_d;
  logic [ByteW-1:0] pend_q, pend_d;
  logic             pend_vld_q, pend_vld_d;
  logic             out_vld_q, out_vld_d;
  out_item_t        out_q, out_d;

  // Memory ports
  logic             par_we, par_re;
  logic [NodeW-1:0] par_waddr, par_raddr;
  logic [InW-1:0]   par_wdata, par_rdata;
  logic             lft_we, lft_re, rgt_we, rgt_re;
  logic [InW-1:0]   lft_waddr, lft_raddr, rgt_waddr, rgt_raddr;
  logic [NodeW-1:0] lft_wdata, lft_rdata, rgt_wdata, rgt_rdata;
  logic             pth_we, pth_re, pth_wdata, pth_rdata;
  logic [InW-1:0]   pth_waddr, pth_raddr;

  logic             out_free;
  logic [InW-1:0]   u_w;
  logic [InW-1:0]   dn_w;
  logic [ByteW-1:0] nb_w;

  sptpe_ram #(.Width(InW), .Depth(NumNodes)) u_parent (
    .clk_i, .we_i(par_we), .waddr_i(par_waddr), .wdata_i(par_wdata),
    .re_i(par_re), .raddr_i(par_raddr), .rdata_o(par_rdata)
  );

  sptpe_ram #(.Width(NodeW), .Depth(ALPHABET)) u_left (
    .clk_i, .we_i(lft_we), .waddr_i(lft_waddr), .wdata_i(lft_wdata),
    .re_i(lft_re), .raddr_i(lft_raddr), .rdata_o(lft_rdata)
  );

  sptpe_ram #(.Width(NodeW), .Depth(ALPHABET)) u_right (
    .clk_i, .we_i(rgt_we), .waddr_i(rgt_waddr), .wdata_i(rgt_wdata),
    .re_i(rgt_re), .raddr_i(rgt_raddr), .rdata_o(rgt_rdata)
  );

  // Path bits of the current code, read back root first
  sptpe_ram #(.Width(1), .Depth(ALPHABET)) u_path (
    .clk_i, .we_i(pth_we), .waddr_i(pth_waddr), .wdata_i(pth_wdata),
    .re_i(pth_re), .raddr_i(pth_raddr), .rdata_o(pth_rdata)
  );

  assign out_free = !out_vld_q || !out_stall_i;
  assign u_w      = inner(par_rdata);
  assign dn_w     = inner(par_rdata);
  assign nb_w     = part_q | (ByteW'(pth_rdata) << bp_q);

  // Sequencer and datapath
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    a_d        = a_q;
    leaf_d     = leaf_q;
    c_d        = c_q;
    d_d        = d_q;
    b_d        = b_q;
    lc_d       = lc_q;
    depth_d    = depth_q;
    is_end_d   = is_end_q;
    bp_d       = bp_q;
    part_d     = part_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    out_vld_d  = out_vld_q && out_stall_i;
    out_d      = out_q;

    par_we = 1'b0; par_waddr = '0; par_wdata = '0;
    par_re = 1'b0; par_raddr = '0;
    lft_we = 1'b0; lft_waddr = '0; lft_wdata = '0;
    lft_re = 1'b0; lft_raddr = '0;
    rgt_we = 1'b0; rgt_waddr = '0; rgt_wdata = '0;
    rgt_re = 1'b0; rgt_raddr = '0;
    pth_we = 1'b0; pth_waddr = '0; pth_wdata = 1'b0;
    pth_re = 1'b0; pth_raddr = '0;

    case (state_q)
      // Rebuild the balanced reset tree, one node per cycle
      S_CLEAR: begin
        par_we    = 1'b1;
        par_waddr = clr_q;
        par_wdata = (clr_q == '0) ? '0 : InW'((clr_q - NodeW'(1)) >> 1);
        if (int'(clr_q) < int'(ALPHABET)) begin
          lft_we    = 1'b1;
          lft_waddr = clr_q[InW-1:0];
          lft_wdata = NodeW'({clr_q, 1'b1});
          rgt_we    = 1'b1;
          rgt_waddr = clr_q[InW-1:0];
          rgt_wdata = NodeW'({clr_q, 1'b0}) + NodeW'(2);
        end
        if (int'(clr_q) == int'(NumNodes) - 1) begin
          clr_d   = '0;
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + NodeW'(1);
        end
      end

      // Take a transaction and start the walk at its leaf
      S_IDLE: begin
        if (in_valid_i) begin
          is_end_d = in_data_i.is_end;
          leaf_d   = in_data_i.is_end ? NodeW'(2 * ALPHABET)
                                      : NodeW'(sym_mod(in_data_i.data_byte)) +
                                        NodeW'(ALPHABET);
          a_d       = leaf_d;
          depth_d   = '0;
          par_re    = 1'b1;
          par_raddr = leaf_d;
          state_d   = S_WALK_B;
        end
      end

      // Parent known: fetch its right child
      S_WALK_B: begin
        c_d       = u_w;
        rgt_re    = 1'b1;
        rgt_raddr = u_w;
        state_d   = S_WALK_C;
      end

      // Record one path bit and climb
      S_WALK_C: begin
        pth_we    = 1'b1;
        pth_waddr = depth_q[InW-1:0];
        pth_wdata = (rgt_rdata == a_q);
        depth_d   = depth_q + (InW+1)'(1);
        a_d       = NodeW'(c_q);
        if (c_q == '0 || int'(depth_d) == int'(ALPHABET)) begin
          state_d = S_EMIT_RD;
        end else begin
          par_re    = 1'b1;
          par_raddr = NodeW'(c_q);
          state_d   = S_WALK_B;
        end
      end

      // Read path bits back from the root side
      S_EMIT_RD: begin
        depth_d   = depth_q - (InW+1)'(1);
        pth_re    = 1'b1;
        pth_raddr = depth_d[InW-1:0];
        state_d   = S_EMIT_BIT;
      end

      // Pack one bit; a full byte goes to the pending register
      S_EMIT_BIT: begin
        if (bp_q != 3'd7) begin
          part_d  = nb_w;
          bp_d    = bp_q + 3'd1;
          state_d = (depth_q == '0) ? S_FLUSH : S_EMIT_RD;
        end else if (!pend_vld_q || out_free) begin
          if (pend_vld_q) begin
            out_vld_d = 1'b1;
            out_d     = '{code_byte: pend_q, last_of_run: 1'b0, stream_done: 1'b0};
          end
          pend_d     = nb_w;
          pend_vld_d = 1'b1;
          part_d     = '0;
          bp_d       = 3'd0;
          state_d    = (depth_q == '0) ? S_FLUSH : S_EMIT_RD;
        end
      end

      // End of stream: push out a partly filled byte; other items pass on
      S_FLUSH: begin
        if (!is_end_q || bp_q == 3'd0) begin
          state_d = S_FIN;
        end else if (!pend_vld_q || out_free) begin
          if (pend_vld_q) begin
            out_vld_d = 1'b1;
            out_d     = '{code_byte: pend_q, last_of_run: 1'b0, stream_done: 1'b0};
          end
          pend_d     = part_q;
          pend_vld_d = 1'b1;
          state_d    = S_FIN;
        end
      end

      // Hand over the last byte of this transaction
      S_FIN: begin
        if (!pend_vld_q || out_free) begin
          if (pend_vld_q) begin
            out_vld_d = 1'b1;
            out_d     = '{code_byte: pend_q, last_of_run: 1'b1,
                          stream_done: is_end_q};
          end
          pend_vld_d = 1'b0;
          if (is_end_q) begin
            bp_d    = 3'd0;
            part_d  = '0;
            clr_d   = '0;
            state_d = S_CLEAR;
          end else begin
            a_d     = leaf_q;
            state_d = S_SPL_A;
          end
        end
      end

      // Semi-splay: fetch parent of a
      S_SPL_A: begin
        par_re    = 1'b1;
        par_raddr = a_q;
        state_d   = S_SPL_B;
      end

      // c = parent(a); stop at root, else fetch c's parent and left child
      S_SPL_B: begin
        if (u_w == '0) begin
          state_d = S_IDLE;
        end else begin
          c_d       = u_w;
          par_re    = 1'b1;
          par_raddr = NodeW'(u_w);
          lft_re    = 1'b1;
          lft_raddr = u_w;
          state_d   = S_SPL_C;
        end
      end

      // d = parent(c); fetch d's children
      S_SPL_C: begin
        d_d       = dn_w;
        lc_d      = lft_rdata;
        lft_re    = 1'b1;
        lft_raddr = dn_w;
        rgt_re    = 1'b1;
        rgt_raddr = dn_w;
        state_d   = S_SPL_D;
      end

      // a replaces c's sibling under d
      S_SPL_D: begin
        if (lft_rdata == NodeW'(c_q)) begin
          b_d       = rgt_rdata;
          rgt_we    = 1'b1;
          rgt_waddr = d_q;
          rgt_wdata = a_q;
        end else begin
          b_d       = lft_rdata;
          lft_we    = 1'b1;
          lft_waddr = d_q;
          lft_wdata = a_q;
        end
        state_d = S_SPL_E;
      end

      // The sibling takes a's place under c
      S_SPL_E: begin
        if (a_q == lc_q) begin
          lft_we    = 1'b1;
          lft_waddr = c_q;
          lft_wdata = b_q;
        end else begin
          rgt_we    = 1'b1;
          rgt_waddr = c_q;
          rgt_wdata = b_q;
        end
        par_we    = 1'b1;
        par_waddr = a_q;
        par_wdata = d_q;
        state_d   = S_SPL_F;
      end

      // Relink the sibling and continue from d
      S_SPL_F: begin
        par_we    = 1'b1;
        par_waddr = b_q;
        par_wdata = c_q;
        a_d       = NodeW'(d_q);
        state_d   = (d_q == '0) ? S_IDLE : S_SPL_A;
      end

      default: begin
        state_d = S_CLEAR;
        clr_d   = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      bp_q       <= 3'd0;
      part_q     <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      bp_q       <= bp_d;
      part_q     <= part_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    leaf_q   <= leaf_d;
    c_q      <= c_d;
    d_q      <= d_d;
    b_q      <= b_d;
    lc_q     <= lc_d;
    depth_q  <= depth_d;
    is_end_q <= is_end_d;
    pend_q   <= pend_d;
    out_q    <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Checks
  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> in_stall_o)
    else $error("input taken during tree rebuild");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.stream_done) |-> out_data_o.last_of_run)
    else $error("stream end without end of run");

  a_end_rebuilds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && state_d == S_CLEAR) |=> (bp_q == 3'd0 && !pend_vld_q))
    else $error("bit buffer not reset after end of stream");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |=> (out_vld_q && $stable(out_q)))
    else $error("stalled output overwritten");

endmodule

// File: test/splay_tree_prefix_encoder_test.sv
// ----------------------------------------------------------------------------
// splay_tree_prefix_encoder_test
// Self-checking bench: a directed table of symbols and end markers, then
// random streams, each output transaction compared with a behavioral tree.
// ----------------------------------------------------------------------------
module splay_tree_prefix_encoder_test;
  import sptpe_pkg::*;

  localparam int unsigned Alpha = AlphabetDef;
  localparam int unsigned NumNodes = 2 * Alpha + 1;
  localparam int unsigned WatchLimit = 20000;

  typedef logic bool_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  splay_tree_prefix_encoder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Behavioral copy of the code tree
  logic [7:0] up_node [NumNodes];
  logic [9:0] lo_kid  [Alpha];
  logic [9:0] hi_kid  [Alpha];
  logic [2:0] fill_pos;
  logic [7:0] fill_byte;

  out_item_t byte_queue [$];
  int        fail_cnt = 0;
  int        idle_cnt = 0;
  bool_t     quiet;

  function automatic int unsigned nix(int unsigned a);
    return (a <= 2 * Alpha) ? a : 0;
  endfunction

  function automatic int unsigned iix(int unsigned c);
    return (c < Alpha) ? c : 0;
  endfunction

  task automatic tree_clear();
    up_node[0] = '0;
    for (int i = 1; i < NumNodes; i++) up_node[i] = 8'((i - 1) >> 1);
    for (int j = 0; j < Alpha; j++) begin
      lo_kid[j] = 10'(2 * j + 1);
      hi_kid[j] = 10'(2 * j + 2);
    end
    fill_pos  = '0;
    fill_byte = '0;
  endtask

  task automatic push_byte(input logic [7:0] v);
    out_item_t o;
    o = '0;
    o.code_byte = v;
    byte_queue.push_back(o);
  endtask

  // Predict the bytes one symbol emits and update the tree
  task automatic encode_symbol(input in_item_t it);
    logic        path [Alpha];
    int unsigned depth, a, u, c, d, b, leaf, n0;
    depth = 0;
    n0 = byte_queue.size();
    leaf = (it.is_end ? Alpha : (it.data_byte % Alpha)) + Alpha;
    a = leaf;
    do begin
      u = iix(up_node[nix(a)]);
      path[depth] = (hi_kid[u] == a);
      depth++;
      a = u;
    end while (a != 0 && depth < Alpha);
    while (depth > 0) begin
      depth--;
      if (path[depth]) fill_byte[fill_pos] = 1'b1;
      if (fill_pos == 3'd7) begin
        push_byte(fill_byte);
        fill_pos = '0;
        fill_byte = '0;
      end else begin
        fill_pos++;
      end
    end
    // semi-splay toward the root
    a = leaf;
    for (int g = 0; g <= Alpha; g++) begin
      c = iix(up_node[nix(a)]);
      if (c == 0) break;
      d = iix(up_node[c]);
      b = lo_kid[d];
      if (c == b) begin
        b = hi_kid[d];
        hi_kid[d] = 10'(a);
      end else begin
        lo_kid[d] = 10'(a);
      end
      if (a == lo_kid[c]) lo_kid[c] = 10'(b);
      else hi_kid[c] = 10'(b);
      up_node[nix(a)] = 8'(d);
      up_node[nix(b)] = 8'(c);
      a = d;
      if (a == 0) break;
    end
    if (it.is_end) begin
      if (fill_pos != 0) push_byte(fill_byte);
      if (byte_queue.size() > n0) byte_queue[$].stream_done = 1'b1;
      tree_clear();
    end
    if (byte_queue.size() > n0) byte_queue[$].last_of_run = 1'b1;
  endtask

  // Output side: random stall, check at the rising edge
  always @(posedge clk_i) begin
    out_item_t exp_item;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (byte_queue.size() == 0) begin
        $display("%0t: unexpected output %h", $time, out_data_o);
        fail_cnt++;
      end else begin
        exp_item = byte_queue.pop_front();
        if (exp_item !== out_data_o) begin
          $display("%0t: mismatch expected %h actual %h", $time, exp_item, out_data_o);
          fail_cnt++;
        end
      end
    end
  end

  always @(negedge clk_i) out_stall_i <= quiet ? 1'b0 : ($urandom_range(99) < 38);

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > WatchLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Drive one input transaction, with a random gap first
  task automatic send_item(input in_item_t it);
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < 38) @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    encode_symbol(it);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Directed symbols: extremes, end on empty stream, end with and without flush
  typedef struct {
    logic [7:0] db;
    logic       ie;
    bit         typed;
    logic [7:0] exp_code;
  } dir_row_t;

  dir_row_t dir_tab [] = '{
    '{8'h00, 1'b1, 1'b1, 8'h00}, // end at once after reset
    '{8'h00, 1'b0, 1'b0, 8'h00},
    '{8'hFF, 1'b0, 1'b0, 8'h00},
    '{8'hFF, 1'b0, 1'b0, 8'h00},
    '{8'h80, 1'b0, 1'b0, 8'h00},
    '{8'h7F, 1'b0, 1'b0, 8'h00},
    '{8'h55, 1'b1, 1'b0, 8'h00}, // data ignored on end
    '{8'hAA, 1'b0, 1'b0, 8'h00},
    '{8'h01, 1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b1, 1'b0, 8'h00},
    '{8'h00, 1'b1, 1'b0, 8'h00},
    '{8'h00, 1'b1, 1'b0, 8'h00},
    '{8'h00, 1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b1, 1'b0, 8'h00}
  };

  initial begin
    in_item_t it;
    int       remaining, cycles_left;
    quiet = 1'b0;
    tree_clear();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[k]) begin
      it.data_byte = dir_tab[k].db;
      it.is_end = dir_tab[k].ie;
      send_item(it);
      // reset end symbol codes eight 0 bits from the root, then a 1
      if (dir_tab[k].typed && byte_queue.size() > 0 &&
          byte_queue[0].code_byte != dir_tab[k].exp_code) begin
        $display("%0t: mismatch expected %h actual %h", $time, dir_tab[k].exp_code,
                 byte_queue[0].code_byte);
        fail_cnt++;
      end
    end

    // Hold the sender until every expected byte is out
    while (byte_queue.size() != 0) @(posedge clk_i);

    // Random streams: mostly a skewed byte set so the splays go deep
    remaining = 420;
    while (remaining > 0) begin
      quiet = (remaining < 140 && remaining > 80);
      it.is_end = ($urandom_range(99) < 4);
      if ($urandom_range(99) < 60) it.data_byte = 8'($urandom_range(7)) ^ 8'h3C;
      else it.data_byte = 8'($urandom_range(255));
      send_item(it);
      remaining--;
    end
    it = '0;
    it.is_end = 1'b1;
    send_item(it);
    quiet = 1'b0;

    cycles_left = 200000;
    while (byte_queue.size() != 0 && cycles_left > 0) begin
      @(posedge clk_i);
      cycles_left--;
    end
    repeat (2000) @(posedge clk_i);
    if (fail_cnt == 0 && byte_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
design/sptpe_pkg.sv
design/sptpe_ram.sv
design/splay_tree_prefix_encoder.sv
test/splay_tree_prefix_encoder_test.sv
